// ----- src/tmq_pkg.sv -----
`default_nettype none
package tmq_pkg;

  localparam int TYPE_W = 64;
  localparam int SIZE_W = 14;
  localparam int CNT_W  = 7;
  localparam int BYTE_W = 21;

  localparam logic [BYTE_W-1:0] BYTE_LIMIT_RESET = 21'd16384;

  localparam logic CMD_SEND = 1'b0;
  localparam logic CMD_RECV = 1'b1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_FULL    = 3'd2,
    ST_NOMSG   = 3'd3,
    ST_TOOBIG  = 3'd4
  } status_e;

  typedef logic signed [TYPE_W-1:0] msg_type_t;

endpackage
`default_nettype wire

// ----- src/tmq_in_if.sv -----
`default_nettype none
interface tmq_in_if;
  import tmq_pkg::*;
  logic                valid;
  logic                ready;
  logic                cmd;
  logic signed [63:0]  msg_type;
  logic [13:0]         msg_size;
  logic                except_flag;
  logic                noerror_flag;

  modport source (output valid, cmd, msg_type, msg_size, except_flag, noerror_flag,
                  input ready);
  modport sink   (input valid, cmd, msg_type, msg_size, except_flag, noerror_flag,
                  output ready);
endinterface
`default_nettype wire

// ----- src/tmq_out_if.sv -----
`default_nettype none
interface tmq_out_if;
  logic                valid;
  logic                ready;
  logic [2:0]          status;
  logic signed [63:0]  out_type;
  logic [13:0]         out_size;
  logic [6:0]          msg_count;
  logic [20:0]         byte_count;

  modport source (output valid, status, out_type, out_size, msg_count, byte_count,
                  input ready);
  modport sink   (input valid, status, out_type, out_size, msg_count, byte_count,
                  output ready);
endinterface
`default_nettype wire

// ----- src/typed_message_queue.sv -----
// a send goes from the input transfer straight to the result; a receive scans every
// used entry, resolves the pick and, when a message is taken, drops dead front entries.
// the entry memory scan reads one entry per cycle and the drop removes one dead
// front entry per cycle. one item at a time: the next input transfer is taken once
// the result has been loaded into the output register, and that load waits while
// the previous result is still stalled at the output.
// reset: asynchronous active-low, empties the ring, clears live marks,
// byte limit back to 16384; entry memory contents are not cleared.
`default_nettype none
module typed_message_queue #(
  parameter int ENTRIES       = 64,
  parameter int MAX_MSG_BYTES = 8192
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [20:0]               cfg_wdata_i,
  tmq_in_if.sink                         in_i,
  tmq_out_if.source                      out_o
);
  import tmq_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int EW = TYPE_W + SIZE_W;
  localparam logic [CW-1:0] ENT_C = CW'(ENTRIES);
  localparam msg_type_t TYPE_MIN = {1'b1, {(TYPE_W-1){1'b0}}};
  localparam msg_type_t TYPE_MAX = {1'b0, {(TYPE_W-1){1'b1}}};

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_RESOLVE = 3'd2;
  localparam logic [2:0] S_DROP    = 3'd3;
  localparam logic [2:0] S_FIN     = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [BYTE_W-1:0] limit_q;
  logic [ENTRIES-1:0] live_q;
  logic [AW-1:0]     head_q;
  logic [CW-1:0]     used_q;
  logic [CW-1:0]     live_cnt_q;
  logic [BYTE_W-1:0] held_q;

  msg_type_t         sel_q;
  logic              except_q, noerror_q;
  logic [SIZE_W-1:0] buf_q;
  logic [CW-1:0]     cnt_q;
  logic              pend_q;
  logic [AW-1:0]     pend_slot_q;
  logic              have_q;
  msg_type_t         best_type_q;
  logic [SIZE_W-1:0] best_size_q;
  logic [AW-1:0]     best_slot_q;

  status_e           res_status_q;
  msg_type_t         res_type_q;
  logic [SIZE_W-1:0] res_size_q;

  logic              out_valid_q;

  logic              in_xfer;
  logic [CW:0]       wsum, rsum;
  logic [AW-1:0]     wslot, rslot;
  logic              send_bad, send_full, send_ok;
  logic [EW-1:0]     rdata;
  msg_type_t         rd_type, bound;
  logic [SIZE_W-1:0] rd_size;
  logic              hit;
  logic              issue;
  logic              out_load;

  assign in_xfer = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign out_load = (state_q == S_FIN) && (!out_valid_q || out_o.ready);

  // ring slot arithmetic, sum stays below twice the depth
  always_comb begin
    wsum = (CW+1)'(head_q) + (CW+1)'(used_q);
    if (wsum >= (CW+1)'(ENTRIES)) wsum = wsum - (CW+1)'(ENTRIES);
    wslot = wsum[AW-1:0];
    rsum = (CW+1)'(head_q) + (CW+1)'(cnt_q);
    if (rsum >= (CW+1)'(ENTRIES)) rsum = rsum - (CW+1)'(ENTRIES);
    rslot = rsum[AW-1:0];
  end

  always_comb begin
    send_bad  = (32'(in_i.msg_size) > 32'(MAX_MSG_BYTES)) || (in_i.msg_type < 64'sd1);
    send_full = ((BYTE_W+1)'(held_q) + (BYTE_W+1)'(in_i.msg_size) > (BYTE_W+1)'(limit_q))
                || (used_q >= ENT_C);
    send_ok   = in_xfer && (in_i.cmd == CMD_SEND) && !send_bad && !send_full;
  end

  assign issue = (state_q == S_SCAN) && (cnt_q < used_q);

  tmq_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (send_ok),
    .waddr_i (wslot),
    .wdata_i ({in_i.msg_type, in_i.msg_size}),
    .raddr_i (rslot),
    .rdata_o (rdata)
  );

  assign rd_type = rdata[EW-1:SIZE_W];
  assign rd_size = rdata[SIZE_W-1:0];

  always_comb begin
    bound = (sel_q == TYPE_MIN) ? TYPE_MAX : -sel_q;
    hit = 1'b0;
    if (pend_q && live_q[pend_slot_q]) begin
      if (sel_q == 64'sd0) begin
        hit = !have_q;
      end else if (sel_q > 64'sd0) begin
        hit = !have_q && (except_q ? (rd_type != sel_q) : (rd_type == sel_q));
      end else begin
        // strict less keeps the earliest on a tie
        hit = (rd_type <= bound) && (!have_q || rd_type < best_type_q);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) state_d = (in_i.cmd == CMD_SEND) ? S_FIN : S_SCAN;
      end
      S_SCAN: begin
        if (!issue && !pend_q) state_d = S_RESOLVE;
      end
      S_RESOLVE: begin
        if (have_q && !(best_size_q > buf_q && !noerror_q)) state_d = S_DROP;
        else state_d = S_FIN;
      end
      S_DROP: begin
        if (used_q == '0 || live_q[head_q]) state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_o.ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      limit_q     <= BYTE_LIMIT_RESET;
      live_q      <= '0;
      head_q      <= '0;
      used_q      <= '0;
      live_cnt_q  <= '0;
      held_q      <= '0;
      pend_q      <= 1'b0;
      have_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            sel_q     <= in_i.msg_type;
            except_q  <= in_i.except_flag;
            noerror_q <= in_i.noerror_flag;
            buf_q     <= in_i.msg_size;
            cnt_q     <= '0;
            pend_q    <= 1'b0;
            have_q    <= 1'b0;
            res_type_q <= '0;
            res_size_q <= '0;
            if (in_i.cmd == CMD_SEND) begin
              if (send_bad) res_status_q <= ST_INVALID;
              else if (send_full) res_status_q <= ST_FULL;
              else res_status_q <= ST_OK;
              if (send_ok) begin
                live_q[wslot] <= 1'b1;
                used_q        <= used_q + 1'b1;
                live_cnt_q    <= live_cnt_q + 1'b1;
                held_q        <= held_q + BYTE_W'(in_i.msg_size);
              end
            end
          end
        end
        S_SCAN: begin
          pend_q      <= issue;
          pend_slot_q <= rslot;
          if (issue) cnt_q <= cnt_q + 1'b1;
          if (hit) begin
            have_q      <= 1'b1;
            best_type_q <= rd_type;
            best_size_q <= rd_size;
            best_slot_q <= pend_slot_q;
          end
        end
        S_RESOLVE: begin
          if (!have_q) begin
            res_status_q <= ST_NOMSG;
          end else if (best_size_q > buf_q && !noerror_q) begin
            res_status_q <= ST_TOOBIG;
          end else begin
            res_status_q <= ST_OK;
            res_type_q   <= best_type_q;
            res_size_q   <= (best_size_q > buf_q) ? buf_q : best_size_q;
            live_q[best_slot_q] <= 1'b0;
            if (live_cnt_q != '0) live_cnt_q <= live_cnt_q - 1'b1;
            held_q <= (held_q >= BYTE_W'(best_size_q)) ? held_q - BYTE_W'(best_size_q) : '0;
          end
        end
        S_DROP: begin
          if (used_q != '0 && !live_q[head_q]) begin
            head_q <= (32'(head_q) == ENTRIES - 1) ? '0 : head_q + 1'b1;
            used_q <= used_q - 1'b1;
          end else if (used_q == '0) begin
            head_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // output register, loaded when the previous result has been transferred
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_o.status     <= res_status_q;
      out_o.out_type   <= res_type_q;
      out_o.out_size   <= res_size_q;
      out_o.msg_count  <= CNT_W'(live_cnt_q);
      out_o.byte_count <= held_q;
    end
  end

  assign out_o.valid = out_valid_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= ENT_C) else $error("ring over-full");
  a_live_le_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_cnt_q <= used_q) else $error("live count above ring use");
  a_live_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(live_q) == 32'(live_cnt_q)) else $error("live marks disagree with count");
  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && used_q == '0) |-> head_q == '0) else $error("empty ring head");

endmodule
`default_nettype wire

// ----- src/tmq_ram.sv -----
`default_nettype none
module tmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  wire logic [WIDTH-1:0]                 wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic      [WIDTH-1:0]                 rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire
